/* rtl/core/bitmap_id_allocator_macros.svh */
// Assertion macros for the bitmap ID allocator.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef BITMAP_ID_ALLOCATOR_MACROS_SVH
`define BITMAP_ID_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define BIA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define BIA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/bia_pkg.sv */
// Shared types and constants of the bitmap ID allocator.
// No dependencies; imported by bia_bitmap_ram and bitmap_id_allocator.
`timescale 1ns / 1ps

package bia_pkg;

    localparam int NUM_IDS_DEF = 256;

    // Bitmap word geometry
    localparam int WORD_W = 32;
    localparam int BIT_W  = 5;

    localparam int ID_W  = 16;
    localparam int OP_W  = 3;
    localparam int CFG_W = 2;

    localparam logic [ID_W-1:0] LOWEST_RST  = 16'd1;
    localparam logic [ID_W-1:0] HIGHEST_RST = 16'd256;
    localparam logic [ID_W-1:0] NONE_RST    = 16'd0;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC_ANY   = 3'd0,
        OP_ALLOC_GIVEN = 3'd1,
        OP_FREE        = 3'd2,
        OP_QUERY       = 3'd3,
        OP_PROBE       = 3'd4
    } t_op;

    typedef enum logic [CFG_W-1:0] {
        CFG_LOWEST  = 2'd0,
        CFG_HIGHEST = 2'd1,
        CFG_NONE    = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_MOD
    } t_state;

endpackage

/* rtl/core/bitmap_id_allocator.sv */
// Top level of the first-fit bitmap ID allocator.
// Depends on bia_pkg, bia_bitmap_ram and bitmap_id_allocator_macros.svh.
`timescale 1ns / 1ps
`include "bitmap_id_allocator_macros.svh"

// The allocator keeps a used/free bit for every ID of the window
// [lowest_id .. min(highest_id, lowest_id + NUM_IDS - 1)] in a RAM of 32-bit
// words with one registered read port and one write port, plus a
// one-entry cache of an ID known to be free. One item is worked at a time,
// and each gives exactly one result beat. Allocate-given, free, query and a
// cached allocate-any go from accept to result through a read step, then a
// modify and write-back step; an item that needs no bitmap access (ID outside
// the window, empty window, probe with a filled cache, unknown op) goes
// straight to the modify step. Allocate-any and probe without a cached ID
// search the bitmap one word per cycle from the bottom of the window, up to
// the first word holding a free ID, at most ceil(window / 32) words.
// The single RAM read port sets that search rate. The result sits in an
// output register, so the next item is taken once the current one has been
// handed to it, even while the result still waits. Each RAM word has a flag
// that reset clears, and a word never written reads as all free: there is no
// clearing pass after reset. Configuration writes are taken only while no
// item is being worked, and a pending write holds off the input channel;
// any write to a known register drops the cached ID.
module bitmap_id_allocator
    import bia_pkg::*;
#(
    parameter int NUM_IDS = NUM_IDS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // input item channel
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [OP_W-1:0]  i_op,
    input  logic [ID_W-1:0]  i_id_value,
    // result channel
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [ID_W-1:0]  o_id_result,
    output logic             o_in_use,
    output logic             o_is_free,
    output logic             o_more_free,
    // configuration write channel
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_index,
    input  logic [ID_W-1:0]  i_cfg_data
);

    localparam int NUM_WORDS = (NUM_IDS + WORD_W - 1) / WORD_W;
    localparam int WORD_AW   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int POS_W     = WORD_AW + BIT_W;     // word index : bit index
    localparam int OFF_W     = $clog2(NUM_IDS);     // offset inside the window
    localparam int CNT_W     = $clog2(NUM_IDS + 1); // window size, 0..NUM_IDS
    localparam int SCAN_W    = WORD_AW + 1;         // search pointer, runs one past

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state             r_state;
    t_state             n_state;

    logic [ID_W-1:0]    r_lowest;
    logic [ID_W-1:0]    r_highest;
    logic [ID_W-1:0]    r_none;

    logic               r_cache_vld;
    logic [OFF_W-1:0]   r_cache_off;

    logic [OP_W-1:0]    r_op;
    logic [ID_W-1:0]    r_id;
    logic               r_inwin;
    logic               r_hit;      // a free target is known (cache or search)
    logic [POS_W-1:0]   r_tgt_pos;  // bitmap position the item works on

    logic [SCAN_W-1:0]  r_scan_addr;
    logic [WORD_AW-1:0] r_chk_addr;
    logic               r_chk_vld;
    logic [WORD_AW-1:0] r_last_word;
    logic [WORD_W-1:0]  r_last_mask;

    logic               r_out_valid;
    logic [ID_W-1:0]    r_id_result;
    logic               r_in_use;
    logic               r_is_free;
    logic               r_more_free;

    // ------------------------------------------------------------------
    // Window geometry, from the configuration registers
    // ------------------------------------------------------------------
    logic [ID_W:0]      span;
    logic [CNT_W-1:0]   win_cnt;
    logic [CNT_W-1:0]   cnt_m1;
    logic [POS_W-1:0]   last_pos;
    logic [ID_W-1:0]    id_diff;
    logic               id_inwin;
    logic [WORD_W-1:0]  n_last_mask;

    always_comb begin
        span = {1'b0, r_highest} - {1'b0, r_lowest} + 17'd1;
        if (r_highest < r_lowest) begin
            win_cnt = '0;
        end else if (span > 17'(NUM_IDS)) begin
            win_cnt = CNT_W'(NUM_IDS);
        end else begin
            win_cnt = span[CNT_W-1:0];
        end
        cnt_m1   = win_cnt - CNT_W'(1);
        last_pos = POS_W'(cnt_m1);
        id_diff  = i_id_value - r_lowest;
        id_inwin = (i_id_value >= r_lowest) && ({1'b0, id_diff} < 17'(win_cnt));
        for (int b = 0; b < WORD_W; b++) begin
            n_last_mask[b] = (BIT_W'(b) <= last_pos[BIT_W-1:0]);
        end
    end

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    logic in_fire;
    logic out_free;
    logic cfg_fire;
    logic mod_fire;

    // a pending register write wins over a new item in the same cycle
    assign o_in_stall  = (r_state != S_IDLE) || i_cfg_valid;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign in_fire     = i_in_valid && !o_in_stall;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign mod_fire    = (r_state == S_MOD) && out_free;

    // ------------------------------------------------------------------
    // Bitmap RAM
    // ------------------------------------------------------------------
    logic               rd_en;
    logic [WORD_AW-1:0] rd_addr;
    logic [WORD_W-1:0]  rd_data;
    logic               wr_en;
    logic [WORD_W-1:0]  wr_data;

    bia_bitmap_ram #(
        .NUM_WORDS (NUM_WORDS),
        .ADDR_W    (WORD_AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_tgt_pos[POS_W-1:BIT_W]),
        .i_wr_data (wr_data)
    );

    // ------------------------------------------------------------------
    // First-fit search over the word just read
    // ------------------------------------------------------------------
    logic [WORD_W-1:0] free_vec;
    logic [BIT_W-1:0]  free_pos;
    logic              scan_hit;
    logic              scan_miss;

    always_comb begin
        free_vec = ~rd_data & ((r_chk_addr == r_last_word) ? r_last_mask : '1);
        free_pos = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (free_vec[b]) begin
                free_pos = BIT_W'(b);
            end
        end
        scan_hit  = (r_state == S_SCAN) && r_chk_vld && (|free_vec);
        scan_miss = (r_state == S_SCAN) && r_chk_vld && !(|free_vec)
                    && (r_chk_addr == r_last_word);
    end

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    case (t_op'(i_op))
                        OP_ALLOC_ANY: begin
                            if (r_cache_vld) begin
                                n_state = S_READ;
                            end else if (win_cnt == '0) begin
                                n_state = S_MOD;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        OP_PROBE: begin
                            if (r_cache_vld || (win_cnt == '0)) begin
                                n_state = S_MOD;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        OP_ALLOC_GIVEN, OP_FREE, OP_QUERY: begin
                            n_state = id_inwin ? S_READ : S_MOD;
                        end
                        default: begin
                            n_state = S_MOD;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_state = S_MOD;
            end
            S_SCAN: begin
                if (scan_hit || scan_miss) begin
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: RAM reads and the result of the modify step
    // ------------------------------------------------------------------
    logic              cur_bit;
    logic [WORD_W-1:0] bit_mask;
    logic              mod_wr;
    logic              cache_clear;
    logic              cache_set;
    logic [ID_W-1:0]   n_id_result;
    logic              n_in_use;
    logic              n_is_free;
    logic              n_more_free;

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_scan_addr[WORD_AW-1:0];
        unique case (r_state)
            S_READ: begin
                rd_en   = 1'b1;
                rd_addr = r_tgt_pos[POS_W-1:BIT_W];
            end
            S_SCAN: begin
                // hold the hit word in the read register: stop reading on a hit
                rd_en = !scan_hit && (r_scan_addr <= {1'b0, r_last_word});
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        cur_bit     = rd_data[r_tgt_pos[BIT_W-1:0]];
        bit_mask    = WORD_W'(1) << r_tgt_pos[BIT_W-1:0];
        mod_wr      = 1'b0;
        wr_data     = rd_data | bit_mask;
        cache_clear = 1'b0;
        cache_set   = 1'b0;
        n_id_result = r_none;
        n_in_use    = 1'b0;
        n_is_free   = 1'b0;
        n_more_free = 1'b0;
        case (t_op'(r_op))
            OP_ALLOC_ANY: begin
                if (r_hit) begin
                    mod_wr      = 1'b1;
                    n_id_result = r_lowest + ID_W'(r_tgt_pos);
                    cache_clear = 1'b1;
                end
            end
            OP_ALLOC_GIVEN: begin
                if (r_inwin && !cur_bit) begin
                    mod_wr      = 1'b1;
                    n_id_result = r_id;
                    cache_clear = r_cache_vld && (POS_W'(r_cache_off) == r_tgt_pos);
                end
            end
            OP_FREE: begin
                if (r_inwin) begin
                    mod_wr  = 1'b1;
                    wr_data = rd_data & ~bit_mask;
                end
            end
            OP_QUERY: begin
                if (r_inwin) begin
                    n_in_use  = cur_bit;
                    n_is_free = !cur_bit;
                end
            end
            OP_PROBE: begin
                n_more_free = r_hit;
                cache_set   = r_hit && !r_cache_vld;
            end
            default: begin
                mod_wr = 1'b0;
            end
        endcase
        wr_en = mod_fire && mod_wr;
    end

    // ------------------------------------------------------------------
    // State and item registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_chk_vld <= 1'b0;
            r_hit     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_fire) begin
                r_hit     <= r_cache_vld;
                r_chk_vld <= 1'b0;
            end else if (r_state == S_SCAN) begin
                r_chk_vld <= rd_en;
                if (scan_hit) begin
                    r_hit <= 1'b1;
                end
            end
        end
    end

    // Item payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op        <= i_op;
            r_id        <= i_id_value;
            r_inwin     <= id_inwin;
            r_scan_addr <= '0;
            r_last_word <= last_pos[POS_W-1:BIT_W];
            r_last_mask <= n_last_mask;
            if (t_op'(i_op) == OP_ALLOC_ANY) begin
                r_tgt_pos <= POS_W'(r_cache_off);
            end else begin
                r_tgt_pos <= POS_W'(id_diff);
            end
        end else if (r_state == S_SCAN) begin
            if (rd_en) begin
                r_scan_addr <= r_scan_addr + SCAN_W'(1);
                r_chk_addr  <= r_scan_addr[WORD_AW-1:0];
            end
            if (scan_hit) begin
                r_tgt_pos <= {r_chk_addr, free_pos};
            end
        end
    end

    // ------------------------------------------------------------------
    // Configuration registers and the free-ID cache
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lowest    <= LOWEST_RST;
            r_highest   <= HIGHEST_RST;
            r_none      <= NONE_RST;
            r_cache_vld <= 1'b0;
            r_cache_off <= '0;
        end else if (cfg_fire) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_LOWEST: begin
                    r_lowest    <= i_cfg_data;
                    r_cache_vld <= 1'b0;
                end
                CFG_HIGHEST: begin
                    r_highest   <= i_cfg_data;
                    r_cache_vld <= 1'b0;
                end
                CFG_NONE: begin
                    r_none      <= i_cfg_data;
                    r_cache_vld <= 1'b0;
                end
                default: begin
                    // unknown index: drop the write
                    r_cache_vld <= r_cache_vld;
                end
            endcase
        end else if (mod_fire) begin
            if (cache_clear) begin
                r_cache_vld <= 1'b0;
            end else if (cache_set) begin
                r_cache_vld <= 1'b1;
                r_cache_off <= r_tgt_pos[OFF_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (mod_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mod_fire) begin
            r_id_result <= n_id_result;
            r_in_use    <= n_in_use;
            r_is_free   <= n_is_free;
            r_more_free <= n_more_free;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_id_result = r_id_result;
    assign o_in_use    = r_in_use;
    assign o_is_free   = r_is_free;
    assign o_more_free = r_more_free;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    logic probe_hit;
    logic alloc_done;

    assign probe_hit  = mod_fire && (r_op == OP_PROBE) && n_more_free;
    assign alloc_done = mod_fire && (r_op == OP_ALLOC_ANY);

    `BIA_ASSERT_NXT(a_one_in_flight, i_clk, i_rst_n, in_fire, o_in_stall, "item taken while busy")
    `BIA_ASSERT_IMP(a_write_in_mod, i_clk, i_rst_n, wr_en, r_state == S_MOD, "stray bitmap write")
    `BIA_ASSERT_NXT(a_probe_fills, i_clk, i_rst_n, probe_hit, r_cache_vld, "probe did not cache")
    `BIA_ASSERT_NXT(a_alloc_drops, i_clk, i_rst_n, alloc_done, !r_cache_vld, "alloc kept cache")

endmodule

/* rtl/core/bia_bitmap_ram.sv */
// Bitmap word RAM of the ID allocator: one write port, one registered read port.
// Depends on bia_pkg for the word width.
`timescale 1ns / 1ps

module bia_bitmap_ram
    import bia_pkg::*;
#(
    parameter int NUM_WORDS = 8,
    parameter int ADDR_W    = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WORD_W-1:0] o_rd_data,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WORD_W-1:0] i_wr_data
);

    logic [WORD_W-1:0]    r_mem [NUM_WORDS];
    logic [NUM_WORDS-1:0] r_word_vld;
    logic [WORD_W-1:0]    r_rd_data;
    logic                 r_rd_vld;

    // Payload array, no reset
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // A word never written reads as all free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_vld <= '0;
            r_rd_vld   <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_word_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_word_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule
